// ===== sv/b64enc_pkg.sv =====
// Shared types, character constants and the Base64 alphabet for the stream encoder.
package b64enc_pkg;

  localparam int unsigned JobChars = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharPad = 8'h3D;
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;

  localparam logic [5:0] GroupsPerLineReset = 6'd19;

  // Register addresses (byte address bit 2 selects the register).
  localparam logic RegWrapEnable    = 1'b0;
  localparam logic RegGroupsPerLine = 1'b1;

  // Characters of one job go out from the lowest slot upwards.
  typedef struct packed {
    logic [JobChars-1:0][7:0] chars;
    logic [2:0]               count;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== sv/b64enc_front.sv =====
// Front end: takes bytes, groups them and builds character jobs with line accounting.
module b64enc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              msg_end_i,
  input  logic              wrap_enable_i,
  input  logic [5:0]        groups_per_line_i,
  output logic              job_valid_o,
  output b64enc_pkg::job_t  job_o
);
  import b64enc_pkg::*;

  logic [1:0] fill_q, fill_d;
  logic [7:0] held0_q, held0_d, held1_q, held1_d;
  logic [5:0] line_q, line_d;
  logic [1:0] fill;
  logic [5:0] line_next;
  logic       line_hit;

  always_comb begin
    fill      = (fill_q == 2'd3) ? 2'd2 : fill_q;
    line_next = line_q + 6'd1;
    line_hit  = (line_next == groups_per_line_i);

    fill_d      = fill_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    line_d      = line_q;
    job_valid_o = 1'b0;
    job_o       = '0;

    if (fill == 2'd2) begin
      job_o.chars[0] = sextet_char(held0_q[7:2]);
      job_o.chars[1] = sextet_char({held0_q[1:0], held1_q[7:4]});
      job_o.chars[2] = sextet_char({held1_q[3:0], data_byte_i[7:6]});
      job_o.chars[3] = sextet_char(data_byte_i[5:0]);
      job_o.chars[4] = CharCr;
      job_o.chars[5] = CharLf;
      job_o.count    = (line_hit && wrap_enable_i) ? 3'd6 : 3'd4;
    end else if (fill == 2'd0) begin
      job_o.chars[0] = sextet_char(data_byte_i[7:2]);
      job_o.chars[1] = sextet_char({data_byte_i[1:0], 4'b0000});
      job_o.chars[2] = CharPad;
      job_o.chars[3] = CharPad;
      job_o.count    = 3'd4;
    end else begin
      job_o.chars[0] = sextet_char(held0_q[7:2]);
      job_o.chars[1] = sextet_char({held0_q[1:0], data_byte_i[7:4]});
      job_o.chars[2] = sextet_char({data_byte_i[3:0], 2'b00});
      job_o.chars[3] = CharPad;
      job_o.count    = 3'd4;
    end

    if (accept_i) begin
      if (fill == 2'd2 || msg_end_i) begin
        job_valid_o = 1'b1;
        fill_d      = 2'd0;
        held0_d     = '0;
        held1_d     = '0;
        if (msg_end_i) begin
          line_d = '0;
        end else begin
          line_d = line_hit ? 6'd0 : line_next;
        end
      end else begin
        if (fill == 2'd0) begin
          held0_d = data_byte_i;
        end else begin
          held1_d = data_byte_i;
        end
        fill_d = fill + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      held0_q <= '0;
      held1_q <= '0;
      line_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      line_q  <= line_d;
    end
  end

endmodule

// ===== sv/b64enc_queue.sv =====
// Short job queue that decouples the front end from the character serialiser.
module b64enc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64enc_pkg::job_t  job_i,
  output logic              full_o,
  input  logic              pop_i,
  output b64enc_pkg::job_t  job_o,
  output logic              empty_o
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/b64enc_back.sv =====
// Back end: shifts the characters of each job out one per cycle into the output register while it is empty or taken.
module b64enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  b64enc_pkg::job_t  job_i,
  output logic              job_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_char_o,
  output logic              run_last_o
);
  import b64enc_pkg::*;

  logic [JobChars-1:0][7:0] chars_q, chars_d;
  logic [2:0]               remain_q, remain_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_char_q, out_char_d;
  logic                     run_last_q, run_last_d;
  logic                     advance, emit, finishing;

  assign empty_o    = !out_valid_q;
  assign out_char_o = out_char_q;
  assign run_last_o = run_last_q;

  always_comb begin
    // The output register can be refilled when it is empty or being taken.
    advance   = !out_valid_q || pop_i;
    emit      = advance && (remain_q != '0);
    finishing = emit && (remain_q == 3'd1);
    job_pop_o = !job_empty_i && ((remain_q == '0) || finishing);

    chars_d     = chars_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    run_last_d  = run_last_q;

    if (advance) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_char_d = chars_q[0];
      run_last_d = finishing;
      chars_d    = chars_q >> 8;
      remain_d   = remain_q - 3'd1;
    end
    if (job_pop_o) begin
      chars_d  = job_i.chars;
      remain_d = job_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q    <= chars_d;
    out_char_q <= out_char_d;
    run_last_q <= run_last_d;
  end

endmodule

// ===== sv/base64_stream_encoder_unit.sv =====
// Base64 stream encoder: one raw byte per item in, one character per item out.
// The characters of a group pass through the job queue, the serialiser shift register and
// the output register. The serialiser in the back end gives one character per cycle while
// pop does not hold the output register; three bytes give four characters, or six when
// CR LF follows, and the final byte of a short group gives four characters.
// Reset clears held bytes, counters, the job queue and the output register; the registers
// return to wrapping off and nineteen groups per line.
module base64_stream_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        msg_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        run_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64enc_pkg::*;

  logic       wrap_enable_q, wrap_enable_d;
  logic [5:0] groups_per_line_q, groups_per_line_d;
  logic       cfg_write;
  logic       accept;
  logic       job_valid;
  job_t       front_job, queue_job;
  logic       queue_full, queue_empty, queue_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    wrap_enable_d     = wrap_enable_q;
    groups_per_line_d = groups_per_line_q;
    if (cfg_write) begin
      case (paddr[2])
        RegWrapEnable:    wrap_enable_d     = pwdata[0];
        RegGroupsPerLine: groups_per_line_d = pwdata[5:0];
        default:          wrap_enable_d     = wrap_enable_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegWrapEnable:    prdata = {31'b0, wrap_enable_q};
      RegGroupsPerLine: prdata = {26'b0, groups_per_line_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_enable_q     <= 1'b0;
      groups_per_line_q <= GroupsPerLineReset;
    end else begin
      wrap_enable_q     <= wrap_enable_d;
      groups_per_line_q <= groups_per_line_d;
    end
  end

  // Every item is held off while the job queue is full, even one that only gets stored.
  assign full   = queue_full;
  assign accept = push && !full;

  b64enc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .msg_end_i         (msg_end_i),
    .wrap_enable_i     (wrap_enable_q),
    .groups_per_line_i (groups_per_line_q),
    .job_valid_o       (job_valid),
    .job_o             (front_job)
  );

  b64enc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (front_job),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .job_o   (queue_job),
    .empty_o (queue_empty)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (queue_empty),
    .job_i       (queue_job),
    .job_pop_o   (queue_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Base64 stream encoder with optional CR LF line wrapping.

typedef struct packed {
  logic [7:0] code;
  logic       fin;
} enc_char_t;

// Tracks the encoder state and holds the characters still due from the block.
class encoder_board;
  bit          wrap_on;
  bit [5:0]    line_limit;
  bit [7:0]    held [2];
  int unsigned fill;
  bit [5:0]    line_count;
  enc_char_t   chars_due [$];
  int          errors;
  string       alphabet;

  function new();
    alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    wrap_on    = 1'b0;
    line_limit = b64enc_pkg::GroupsPerLineReset;
    errors     = 0;
    clear_message();
  endfunction

  function void clear_message();
    held[0]    = '0;
    held[1]    = '0;
    fill       = 0;
    line_count = '0;
  endfunction

  function void set_reg(logic idx, logic [31:0] value);
    if (idx == b64enc_pkg::RegWrapEnable) begin
      wrap_on = value[0];
    end else begin
      line_limit = value[5:0];
    end
  endfunction

  function logic [7:0] sextet(bit [5:0] v);
    return alphabet[v];
  endfunction

  // Works out the characters that one accepted byte causes.
  function void take_byte(bit [7:0] b, bit fin);
    logic [7:0] grp [$];
    enc_char_t  item;
    if (fill == 2) begin
      grp.push_back(sextet(held[0][7:2]));
      grp.push_back(sextet({held[0][1:0], held[1][7:4]}));
      grp.push_back(sextet({held[1][3:0], b[7:6]}));
      grp.push_back(sextet(b[5:0]));
      // The line counter runs even with wrapping off; only CR LF is suppressed.
      line_count = line_count + 6'd1;
      if (line_count == line_limit) begin
        line_count = '0;
        if (wrap_on) begin
          grp.push_back(b64enc_pkg::CharCr);
          grp.push_back(b64enc_pkg::CharLf);
        end
      end
      fill    = 0;
      held[0] = '0;
      held[1] = '0;
      if (fin) clear_message();
    end else if (fin) begin
      if (fill == 0) begin
        grp.push_back(sextet(b[7:2]));
        grp.push_back(sextet({b[1:0], 4'b0000}));
        grp.push_back(b64enc_pkg::CharPad);
        grp.push_back(b64enc_pkg::CharPad);
      end else begin
        grp.push_back(sextet(held[0][7:2]));
        grp.push_back(sextet({held[0][1:0], b[7:4]}));
        grp.push_back(sextet({b[3:0], 2'b00}));
        grp.push_back(b64enc_pkg::CharPad);
      end
      clear_message();
    end else begin
      held[fill] = b;
      fill++;
    end
    foreach (grp[i]) begin
      item.code = grp[i];
      item.fin  = (i == grp.size() - 1);
      chars_due.push_back(item);
    end
  endfunction

  function void check_char(logic [7:0] code, logic fin);
    enc_char_t want;
    if (chars_due.size() == 0) begin
      errors++;
      $display("%0t: character expected none, actual %h (run_last %b)", $time, code, fin);
      return;
    end
    want = chars_due.pop_front();
    if (code !== want.code) begin
      errors++;
      $display("%0t: out_char expected %h, actual %h", $time, want.code, code);
    end
    if (fin !== want.fin) begin
      errors++;
      $display("%0t: run_last expected %b, actual %b", $time, want.fin, fin);
    end
  endfunction

  function int pending();
    return chars_due.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 300000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 300;
  localparam int NumPhases    = 6;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        msg_end_i   = 1'b0;
  logic        pop         = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        full;
  logic        empty;
  logic [7:0]  out_char_o;
  logic        run_last_o;
  logic [31:0] prdata;
  logic        pready;

  encoder_board board = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int msg_left  = 0;
  int cycle_count;

  // Settings per phase: the two extremes of the line limit get long messages.
  bit       phase_wrap  [NumPhases] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  bit [5:0] phase_limit [NumPhases] = '{6'd1, 6'd63, 6'd2, 6'd0, 6'd3, 6'd1};
  int       phase_items [NumPhases] = '{20, 200, 40, 200, 20, 20};
  bit       phase_long  [NumPhases] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
  int       phase_idle  [NumPhases] = '{0, 58, 0, 27, 0, 27};
  int       phase_stall [NumPhases] = '{0, 0, 58, 27, 0, 27};

  // {msg_end, data_byte}: padding both ways, a final full group, all-zero and all-one bytes.
  logic [8:0] directed_items [20] = '{
    9'h100, 9'h1FF, 9'h000, 9'h1FF, 9'h0FF, 9'h100, 9'h0FF, 9'h0FF, 9'h1FF, 9'h000,
    9'h000, 9'h100, 9'h04D, 9'h061, 9'h06E, 9'h0FB, 9'h0EF, 9'h0BE, 9'h010, 9'h183
  };

  base64_stream_encoder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .msg_end_i   (msg_end_i),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk_i = ~clk_i;

  // push is left high after an acceptance so that back-to-back items need no gap.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    msg_end_i   <= fin;
    do @(posedge clk_i); while (full);
    board.take_byte(b, fin);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // A held byte causes no character, so settling time is allowed after the last one.
  task automatic drain();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_random(input bit long_msgs);
    logic [7:0] b;
    if (msg_left == 0) begin
      if (long_msgs && $urandom_range(0, 9) < 7) msg_left = $urandom_range(190, 260);
      else msg_left = $urandom_range(1, 12);
    end
    b = $urandom_range(0, 255);
    send_byte(b, msg_left == 1);
    msg_left--;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("base64_stream_encoder_unit test failed");
    $finish;
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) board.check_char(out_char_o, run_last_o);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_items[i]) send_byte(directed_items[i][7:0], directed_items[i][8]);
    drain();

    // Messages may run on across a phase boundary, so a lowered limit meets a higher count.
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(b64enc_pkg::RegWrapEnable, {31'd0, phase_wrap[p]});
      write_reg(b64enc_pkg::RegGroupsPerLine, {26'd0, phase_limit[p]});
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 2) hold_left = HoldCycles;
      for (int i = 0; i < phase_items[p]; i++) begin
        if (i == phase_items[p] / 2) drain();
        send_random(phase_long[p]);
      end
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("base64_stream_encoder_unit test passed");
    end else begin
      $display("base64_stream_encoder_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/b64enc_pkg.sv
sv/b64enc_front.sv
sv/b64enc_queue.sv
sv/b64enc_back.sv
sv/base64_stream_encoder_unit.sv
test/tb.sv
